// ===== rtl/pcmd_pkg.sv =====
// pcmd_pkg: shared constants, types and codes of the pointer click and motion detector
// no dependencies; imported by every module of the block but pcmd_state_ram
`default_nettype none

package pcmd_pkg;

    localparam int MICE     = 4;
    localparam int BUTTONS  = 10;
    localparam int AXES     = 4;
    localparam int MOUSE_AW = 2;   // address of one device entry, MICE entries
    localparam int AXIS_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int IN_DW    = 112;
    localparam int OUT_DW   = 112;

    // operation selector
    localparam logic OP_BUTTON = 1'b0;
    localparam logic OP_MOTION = 1'b1;

    // configuration register indexes
    localparam logic CFG_WINDOW   = 1'b0;
    localparam logic CFG_DISTANCE = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd300;
    localparam logic [CFG_W-1:0] DISTANCE_RESET = 16'd2;

    // result kinds
    localparam logic [2:0] EV_MOVE   = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_CLICK  = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;

    localparam logic [3:0] NO_BUTTON = 4'hf;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [2:0]               t_kind;

    typedef struct packed {
        logic                   op;
        logic [2:0]             mouse;
        logic [3:0]             button;
        logic                   pressed;
        logic [2:0]             axis_count;
        t_axis [AXES-1:0]       ax;
        logic [TIME_W-1:0]      time_tick;
        logic [2:0]             mods;
    } t_item;

    // one state entry per device
    typedef struct packed {
        t_axis [AXES-1:0]       pos;
        logic [2:0]             axis_cnt;
        logic                   click_valid;
        logic [3:0]             click_btn;
        logic [TIME_W-1:0]      click_time;
        t_axis [AXES-1:0]       click_pos;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        pos:         '0,
        axis_cnt:    '0,
        click_valid: 1'b0,
        click_btn:   NO_BUTTON,
        click_time:  '0,
        click_pos:   '0
    };

    // results of one item, handed from the update logic to the event queue
    typedef struct packed {
        logic [1:0]             count;
        t_kind [2:0]            kinds;
        logic [AXES-1:0]        mask;
    } t_res;

    typedef struct packed {
        logic [2:0]             mouse;
        logic [3:0]             button;
        logic [3:0]             mask;
        logic [2:0]             mods;
        logic [TIME_W-1:0]      time_tick;
        t_axis [3:0]            ax;
    } t_evt;

endpackage

`default_nettype wire

// ===== rtl/pcmd_state_ram.sv =====
// pcmd_state_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module pcmd_state_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcmd_update.sv =====
// pcmd_update: read-modify-write logic for one device entry and result selection
// depends on pcmd_pkg
`default_nettype none

module pcmd_update
    import pcmd_pkg::*;
(
    input  wire t_item            i_item,
    input  wire t_entry           i_old,
    input  wire logic [CFG_W-1:0] i_window,
    input  wire logic [CFG_W-1:0] i_distance,
    output t_entry                o_new,
    output t_res                  o_res
);

    logic [2:0]        n_axes;
    logic [2:0]        click_cnt;
    logic [AXES-1:0]   mask;
    logic              btn_ok;
    logic [TIME_W-1:0] dt;
    logic              match;
    logic              near;
    logic              record;
    logic [16:0]       diff [AXES];
    logic [16:0]       dist_abs [AXES];
    logic [1:0]        k;

    always_comb begin
        n_axes = (i_item.axis_count > 3'(AXES)) ? 3'(AXES) : i_item.axis_count;
        for (int i = 0; i < AXES; i++) begin
            mask[i] = (3'(i) < n_axes) && (i_old.pos[i] != i_item.ax[i]);
        end

        o_new = i_old;
        if (mask != '0) begin
            for (int i = 0; i < AXES; i++) begin
                if (3'(i) < n_axes) begin
                    o_new.pos[i] = i_item.ax[i];
                end
            end
            o_new.axis_cnt = n_axes;
        end

        click_cnt = (o_new.axis_cnt > 3'(AXES)) ? 3'(AXES) : o_new.axis_cnt;
        btn_ok = (i_item.op == OP_BUTTON) && (i_item.button != '0)
                 && (i_item.button <= 4'(BUTTONS));

        // elapsed ticks wrap modulo 2^32
        dt    = i_item.time_tick - i_old.click_time;
        match = i_old.click_valid && (i_old.click_btn == i_item.button)
                && (dt <= {{(TIME_W-CFG_W){1'b0}}, i_window});

        near = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            diff[i] = {i_item.ax[i][AXIS_W-1], i_item.ax[i]}
                      - {i_old.click_pos[i][AXIS_W-1], i_old.click_pos[i]};
            dist_abs[i] = diff[i][16] ? (17'd0 - diff[i]) : diff[i];
            if ((3'(i) < click_cnt) && (dist_abs[i] > {1'b0, i_distance})) begin
                near = 1'b0;
            end
        end

        o_res.kinds = {EV_MOVE, EV_MOVE, EV_MOVE};
        o_res.mask  = mask;
        k = '0;
        if (mask != '0) begin
            o_res.kinds[k] = EV_MOVE;
            k = k + 2'd1;
        end

        record = i_item.pressed;
        if (btn_ok) begin
            o_res.kinds[k] = i_item.pressed ? EV_DOWN : EV_UP;
            k = k + 2'd1;
            if (match) begin
                if (near) begin
                    o_res.kinds[k] = i_item.pressed ? EV_DOUBLE : EV_CLICK;
                    k = k + 2'd1;
                    record = 1'b0;
                    // a double click clears the reference; a click keeps it armed
                    if (i_item.pressed) begin
                        o_new.click_btn   = NO_BUTTON;
                        o_new.click_valid = 1'b0;
                    end
                end else begin
                    record = 1'b1;
                end
            end
            if (record) begin
                o_new.click_btn   = i_item.button;
                o_new.click_valid = 1'b1;
                o_new.click_time  = i_item.time_tick;
                for (int i = 0; i < AXES; i++) begin
                    if (3'(i) < click_cnt) begin
                        o_new.click_pos[i] = i_item.ax[i];
                    end
                end
            end
        end
        o_res.count = k;
    end

endmodule

`default_nettype wire

// ===== rtl/pcmd_event_queue.sv =====
// pcmd_event_queue: output register holding the up to three results of one item
// depends on pcmd_pkg
`default_nettype none

module pcmd_event_queue
    import pcmd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_res i_res,
    input  wire t_evt i_evt,
    input  wire logic i_ready,
    output logic      o_free,
    output logic      o_valid,
    output logic      o_last,
    output t_kind     o_kind,
    output t_evt      o_evt
);

    logic [1:0]  r_left;
    logic [1:0]  n_left;
    t_kind [2:0] r_kinds;
    t_evt        r_evt;
    logic        xfer;

    assign o_valid = (r_left != '0);
    assign o_last  = (r_left == 2'd1);
    assign xfer    = o_valid && i_ready;
    assign o_free  = (r_left == '0) || (o_last && i_ready);
    assign o_kind  = r_kinds[0];

    // button only on button events, mask only on the move event
    always_comb begin
        o_evt = r_evt;
        if (r_kinds[0] == EV_MOVE) begin
            o_evt.button = '0;
        end else begin
            o_evt.mask = '0;
        end
    end

    always_comb begin
        n_left = r_left;
        if (i_load) begin
            n_left = i_res.count;
        end else if (xfer) begin
            n_left = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kinds        <= i_res.kinds;
            r_evt          <= i_evt;
        end else if (xfer) begin
            r_kinds <= {EV_MOVE, r_kinds[2], r_kinds[1]};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pointer_click_motion_detector.sv =====
// pointer_click_motion_detector: top level, input stage, state ram with forwarding, config
// depends on pcmd_pkg, pcmd_state_ram, pcmd_update, pcmd_event_queue
//
//  port group     dir  payload
//  s_axis_*       in   tuser: operation; tdata: device, button, press, axes, time, modifiers
//  m_axis_*       out  tuser: event kind; tdata: device..axes; tlast: last of run
//  i_cfg_*        in   register index, 16-bit write data, no read-back
//
// an item that causes at most one result does not hold up the next while the output is
// not stalled; otherwise the output register sets the pace, and the next item waits.
// the device entry is read at transfer and written back when the item leaves the input
// stage; a write to the entry being read is forwarded from the last-write register.
// reset clears all device entries at once through per-entry valid flags.
// a stalled output holds the input stage, and tready falls only while it is full.
`default_nettype none

module pointer_click_motion_detector
    import pcmd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: mouse_index, button_index, pressed, axis_count, axis_0..axis_3, tick_time,
    //        modifier_flags, 2 zero bits
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    // tuser: operation
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // tdata: event_mouse, event_button, changed_axes, event_modifiers, event_time,
    //        out_axis_0..out_axis_3, 2 zero bits
    output logic      [OUT_DW-1:0] m_axis_tdata,
    // tuser: event_kind
    output logic      [2:0]        m_axis_tuser,
    output logic                   m_axis_tlast,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata
);

    logic [CFG_W-1:0]    r_window;
    logic [CFG_W-1:0]    r_distance;

    t_item               in_item;
    logic                accept;
    logic [2:0]          in_addr_full;
    logic                in_ok;

    logic                r_s1_v;
    t_item               r_s1_item;
    logic [MOUSE_AW-1:0] r_s1_addr;
    logic                r_s1_ok;
    logic                r_rd_init;
    logic                fire;

    logic [MICE-1:0]     r_init;
    logic                r_fwd_v;
    logic [MOUSE_AW-1:0] r_fwd_addr;
    t_entry              r_fwd_data;

    logic [$bits(t_entry)-1:0] rdata;
    t_entry              old_entry;
    t_entry              new_entry;
    t_res                res;
    t_evt                evt_in;
    t_evt                evt_out;
    t_kind               out_kind;
    logic                q_free;
    logic                mem_we;

    assign in_item.op         = s_axis_tuser;
    assign in_item.mouse      = s_axis_tdata[2:0];
    assign in_item.button     = s_axis_tdata[6:3];
    assign in_item.pressed    = s_axis_tdata[7];
    assign in_item.axis_count = s_axis_tdata[10:8];
    assign in_item.ax[0]      = s_axis_tdata[26:11];
    assign in_item.ax[1]      = s_axis_tdata[42:27];
    assign in_item.ax[2]      = s_axis_tdata[58:43];
    assign in_item.ax[3]      = s_axis_tdata[74:59];
    assign in_item.time_tick  = s_axis_tdata[106:75];
    assign in_item.mods       = s_axis_tdata[109:107];

    assign in_addr_full  = in_item.mouse - 3'd1;
    assign in_ok         = (in_item.mouse != '0) && ({1'b0, in_item.mouse} <= 4'(MICE));
    assign fire          = r_s1_v && q_free;
    assign s_axis_tready = !r_s1_v || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = fire && r_s1_ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RESET;
            r_distance <= DISTANCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WINDOW:   r_window   <= i_cfg_wdata;
                CFG_DISTANCE: r_distance <= i_cfg_wdata;
                default:      r_window   <= r_window;
            endcase
        end
    end

    // input stage, the entry read is issued on the same transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (fire) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= in_item;
            r_s1_addr <= in_addr_full[MOUSE_AW-1:0];
            r_s1_ok   <= in_ok;
            r_rd_init <= r_init[in_addr_full[MOUSE_AW-1:0]];
        end
    end

    pcmd_state_ram #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (MICE),
        .ADDR_W (MOUSE_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_entry),
        .i_re    (accept),
        .i_raddr (in_addr_full[MOUSE_AW-1:0]),
        .o_rdata (rdata)
    );

    // entry valid flags and last-write register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_fwd_v <= 1'b0;
        end else if (mem_we) begin
            r_init[r_s1_addr] <= 1'b1;
            r_fwd_v           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= new_entry;
        end
    end

    always_comb begin
        if (r_fwd_v && (r_fwd_addr == r_s1_addr)) begin
            old_entry = r_fwd_data;
        end else if (r_rd_init) begin
            old_entry = t_entry'(rdata);
        end else begin
            old_entry = ENTRY_RESET;
        end
    end

    pcmd_update u_update (
        .i_item     (r_s1_item),
        .i_old      (old_entry),
        .i_window   (r_window),
        .i_distance (r_distance),
        .o_new      (new_entry),
        .o_res      (res)
    );

    always_comb begin
        evt_in.mouse     = r_s1_item.mouse;
        evt_in.button    = r_s1_item.button;
        evt_in.mask      = 4'(res.mask);
        evt_in.mods      = r_s1_item.mods;
        evt_in.time_tick = r_s1_item.time_tick;
        evt_in.ax        = r_s1_item.ax;
    end

    pcmd_event_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (mem_we),
        .i_res   (res),
        .i_evt   (evt_in),
        .i_ready (m_axis_tready),
        .o_free  (q_free),
        .o_valid (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_kind  (out_kind),
        .o_evt   (evt_out)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {2'b00, evt_out.ax[3], evt_out.ax[2], evt_out.ax[1],
                           evt_out.ax[0], evt_out.time_tick, evt_out.mods,
                           evt_out.mask, evt_out.button, evt_out.mouse};

    // a run that is not finished keeps the output valid
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("result run broken off");

    // a write-back always leaves the forwarding register holding that entry
    a_fwd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_fwd_v && (r_fwd_addr == $past(r_s1_addr)))
        else $error("forwarding register out of step with write-back");

    // the input side stalls only behind a held item
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_v && !q_free)
        else $error("input stalled without a held item");

    // an item for an unknown device never touches the state
    a_bad_mouse_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_s1_ok |=> !$past(mem_we) && ($past(r_init) == r_init))
        else $error("state written for an invalid device");

endmodule

`default_nettype wire

// ===== test/pointer_click_motion_detector_tb.sv =====
// pointer_click_motion_detector_tb: self-checking bench for the pointer click and motion detector
// drives item transfers from a queue, predicts the events in-line and checks every result transfer
// depends on pcmd_pkg and pointer_click_motion_detector
`default_nettype none

module pointer_click_motion_detector_tb;
    import pcmd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        t_kind             kind;
        logic [2:0]        mouse;
        logic [3:0]        button;
        logic [3:0]        mask;
        logic [2:0]        mods;
        logic [TIME_W-1:0] tick;
        t_axis [3:0]       ax;
        logic              last;
    } t_pointer_event;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_addr = CFG_WINDOW;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    pointer_click_motion_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor state, one entry per device
    t_axis             pos_store [MICE][AXES];
    int                axes_store [MICE];
    logic [3:0]        click_btn [MICE];
    bit                click_armed [MICE];
    logic [TIME_W-1:0] click_tick [MICE];
    t_axis             click_pos [MICE][AXES];
    logic [CFG_W-1:0]  window_ticks = WINDOW_RESET;
    logic [CFG_W-1:0]  distance_limit = DISTANCE_RESET;

    t_item             pending_items [$];
    t_pointer_event    expected_events [$];
    t_item             cur_item;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;
    int                items_sent = 0;
    int                events_seen = 0;
    int                clicks_seen = 0;
    int                doubles_seen = 0;
    int                quiet_cycles = 0;
    logic [TIME_W-1:0] gen_tick = '0;

    initial begin
        for (int m = 0; m < MICE; m++) begin
            axes_store[m] = 0;
            click_btn[m] = NO_BUTTON;
            click_armed[m] = 1'b0;
            click_tick[m] = '0;
            for (int a = 0; a < AXES; a++) begin
                pos_store[m][a] = '0;
                click_pos[m][a] = '0;
            end
        end
    end

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item make_item(logic op, int mouse, int button, logic pr, int n,
                                        int a0, int a1, int a2, int a3,
                                        logic [TIME_W-1:0] tick, int mods);
        t_item it;
        it.op = op;
        it.mouse = mouse[2:0];
        it.button = button[3:0];
        it.pressed = pr;
        it.axis_count = n[2:0];
        it.ax[0] = a0[15:0];
        it.ax[1] = a1[15:0];
        it.ax[2] = a2[15:0];
        it.ax[3] = a3[15:0];
        it.time_tick = tick;
        it.mods = mods[2:0];
        return it;
    endfunction

    function automatic t_pointer_event make_event(t_kind kind, t_item it, logic [3:0] mask);
        t_pointer_event ev;
        ev.kind = kind;
        ev.mouse = it.mouse;
        ev.button = (kind == EV_MOVE) ? 4'd0 : it.button;
        ev.mask = mask;
        ev.mods = it.mods;
        ev.tick = it.time_tick;
        ev.ax = it.ax;
        ev.last = 1'b0;
        return ev;
    endfunction

    // works out the events one accepted item causes and updates the device state
    task automatic predict_events(input t_item it);
        t_pointer_event    run [$];
        int                m;
        int                n;
        int                cnt;
        int                d;
        int                in_ax;
        int                ref_ax;
        logic [3:0]        mask;
        logic [TIME_W-1:0] dt;
        bit                near;
        bit                record;
        if (it.mouse < 1 || it.mouse > MICE)
            return;
        m = it.mouse - 1;
        n = (it.axis_count > AXES) ? AXES : it.axis_count;
        mask = '0;
        for (int a = 0; a < n; a++)
            if (pos_store[m][a] != it.ax[a])
                mask[a] = 1'b1;
        if (mask != 0) begin
            for (int a = 0; a < n; a++)
                pos_store[m][a] = it.ax[a];
            axes_store[m] = n;
            run.push_back(make_event(EV_MOVE, it, mask));
        end
        if (it.op == OP_BUTTON && it.button >= 1 && it.button <= BUTTONS) begin
            record = it.pressed;
            cnt = axes_store[m];
            run.push_back(make_event(it.pressed ? EV_DOWN : EV_UP, it, 4'd0));
            dt = it.time_tick - click_tick[m];
            if (click_armed[m] && click_btn[m] == it.button && dt <= {16'd0, window_ticks}) begin
                near = 1'b1;
                for (int a = 0; a < cnt; a++) begin
                    in_ax = t_axis'(it.ax[a]);
                    ref_ax = click_pos[m][a];
                    d = in_ax - ref_ax;
                    if (d < 0)
                        d = -d;
                    if (d > int'(distance_limit))
                        near = 1'b0;
                end
                if (near) begin
                    run.push_back(make_event(it.pressed ? EV_DOUBLE : EV_CLICK, it, 4'd0));
                    record = 1'b0;
                    if (it.pressed) begin
                        click_btn[m] = NO_BUTTON;
                        click_armed[m] = 1'b0;
                    end
                end else begin
                    record = 1'b1;
                end
            end
            if (record) begin
                click_btn[m] = it.button;
                click_armed[m] = 1'b1;
                click_tick[m] = it.time_tick;
                for (int a = 0; a < cnt; a++)
                    click_pos[m][a] = it.ax[a];
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[k])
            expected_events.push_back(run[k]);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // driver: one item per transfer, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_events(cur_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata <= {2'b00, cur_item.mods, cur_item.time_tick,
                                     cur_item.ax[3], cur_item.ax[2], cur_item.ax[1], cur_item.ax[0],
                                     cur_item.axis_count, cur_item.pressed, cur_item.button,
                                     cur_item.mouse};
                    s_axis_tuser <= cur_item.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transfer with the oldest expected event
    always @(posedge i_clk) begin
        t_pointer_event ev;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
                $error("unexpected result: kind %0d device %0d", m_axis_tuser, m_axis_tdata[2:0]);
                mismatches++;
            end else begin
                ev = expected_events.pop_front();
                if (ev.kind == EV_CLICK)
                    clicks_seen++;
                if (ev.kind == EV_DOUBLE)
                    doubles_seen++;
                check_field("event_kind", 32'(ev.kind), 32'(m_axis_tuser));
                check_field("event_mouse", 32'(ev.mouse), 32'(m_axis_tdata[2:0]));
                check_field("event_button", 32'(ev.button), 32'(m_axis_tdata[6:3]));
                check_field("changed_axes", 32'(ev.mask), 32'(m_axis_tdata[10:7]));
                check_field("event_modifiers", 32'(ev.mods), 32'(m_axis_tdata[13:11]));
                check_field("event_time", ev.tick, m_axis_tdata[45:14]);
                for (int a = 0; a < 4; a++)
                    check_field($sformatf("out_axis_%0d", a), {16'd0, ev.ax[a]},
                                {16'd0, m_axis_tdata[46 + 16*a +: 16]});
                check_field("last_of_run", 32'(ev.last), 32'(m_axis_tlast));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // predictor copy of the registers, sampled the way the block samples them
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            if (i_cfg_addr == CFG_WINDOW)
                window_ticks <= i_cfg_wdata;
            else
                distance_limit <= i_cfg_wdata;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (pending_items.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("pointer_click_motion_detector test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold off until every item has gone and every event has come, then let the pipe settle
    task automatic drain;
        do
            @(posedge i_clk);
        while (pending_items.size() > 0 || s_axis_tvalid || expected_events.size() > 0);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] next_tick();
        case ($urandom_range(0, 3))
            0: gen_tick = gen_tick;
            1: gen_tick = gen_tick + $urandom_range(0, window_ticks);
            2: gen_tick = gen_tick + window_ticks + $urandom_range(1, 50);
            default: gen_tick = gen_tick + $urandom_range(0, 8);
        endcase
        return gen_tick;
    endfunction

    function automatic int jitter();
        case ($urandom_range(0, 5))
            0, 1: return 0;
            2, 3: return $urandom_range(0, 6) - 3;
            4: return $urandom_range(0, int'(distance_limit) + 3) - 1;
            default: return $urandom_range(0, 400) - 200;
        endcase
    endfunction

    // a press/release run on one device and mostly one button, with hand shake between edges
    task automatic add_click_run(inout int added);
        int m;
        int b;
        int n;
        int steps;
        int mods;
        int base [4];
        m = $urandom_range(1, MICE);
        b = $urandom_range(1, BUTTONS);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, AXES);
        mods = $urandom_range(0, 7);
        for (int a = 0; a < 4; a++)
            base[a] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                                   : $urandom_range(0, 40) - 20;
        steps = $urandom_range(2, 5);
        for (int s = 0; s < steps; s++) begin
            if ($urandom_range(0, 5) == 0) begin
                pending_items.push_back(make_item(OP_MOTION, m, $urandom_range(0, 15),
                    1'($urandom_range(0, 1)), n, base[0] + jitter(), base[1] + jitter(),
                    base[2] + jitter(), base[3] + jitter(), next_tick(), mods));
                added++;
            end
            // an odd button now and then breaks the pairing
            pending_items.push_back(make_item(OP_BUTTON, m,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : b,
                (s % 2 == 0), n, base[0] + jitter(), base[1] + jitter(),
                base[2] + jitter(), base[3] + jitter(), next_tick(),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : mods));
            added++;
        end
    endtask

    task automatic add_random(int count);
        int added;
        t_item it;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 99) < 85) begin
                add_click_run(added);
            end else begin
                it = make_item(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                               $urandom_range(0, 15),
                               1'($urandom_range(0, 1)), $urandom_range(0, 7),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom(), $urandom_range(0, 7));
                pending_items.push_back(it);
                if (it.mouse >= 1 && it.mouse <= MICE)
                    added++;
            end
        end
    endtask

    task automatic add_directed;
        // full-scale axes, then the same position again
        pending_items.push_back(make_item(OP_MOTION, 1, 0, 0, 4, -32768, 32767, 0, -1, 10, 1));
        pending_items.push_back(make_item(OP_MOTION, 1, 0, 0, 4, -32768, 32767, 0, -1, 20, 2));
        // devices out of range
        pending_items.push_back(make_item(OP_MOTION, 0, 0, 0, 4, 5, 5, 5, 5, 30, 7));
        pending_items.push_back(make_item(OP_BUTTON, 5, 1, 1, 4, 5, 5, 5, 5, 31, 7));
        pending_items.push_back(make_item(OP_BUTTON, 7, 15, 1, 7, -1, -1, -1, -1, 32, 7));
        // no valid axes, then an axis count above the limit
        pending_items.push_back(make_item(OP_MOTION, 2, 0, 0, 0, 9, -9, 9, -9, 40, 3));
        pending_items.push_back(make_item(OP_MOTION, 2, 0, 0, 7, 1, 2, 3, 4, 41, 4));
        // click then double click on button 1
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 1, 4, -32768, 32767, 0, -1, 100, 0));
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 0, 4, -32768, 32767, 0, -1, 150, 5));
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 1, 4, -32768, 32767, 0, -1, 200, 6));
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 0, 4, -32768, 32767, 0, -1, 250, 0));
        // double click with a move inside the distance: three events
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 1, 4, -32767, 32767, 0, -1, 300, 1));
        pending_items.push_back(make_item(OP_BUTTON, 1, 1, 1, 4, -32765, 32766, 1, -2, 400, 2));
        // far-away release re-arms the reference
        pending_items.push_back(make_item(OP_BUTTON, 3, 2, 1, 2, 0, 0, 0, 0, 1000, 0));
        pending_items.push_back(make_item(OP_BUTTON, 3, 2, 0, 2, 50, 0, 7, 7, 1100, 0));
        pending_items.push_back(make_item(OP_BUTTON, 3, 2, 1, 2, 50, 0, 7, 7, 1150, 0));
        // buttons out of range only do the motion check
        pending_items.push_back(make_item(OP_BUTTON, 4, 0, 1, 1, 3, 0, 0, 0, 1200, 7));
        pending_items.push_back(make_item(OP_BUTTON, 4, 11, 1, 1, 4, 0, 0, 0, 1201, 7));
        pending_items.push_back(make_item(OP_BUTTON, 4, 15, 0, 1, 4, 0, 0, 0, 1202, 7));
        // window across the tick wrap
        pending_items.push_back(make_item(OP_BUTTON, 4, 10, 1, 1, 4, 0, 0, 0, 32'hffff_fff0, 0));
        pending_items.push_back(make_item(OP_BUTTON, 4, 10, 1, 1, 4, 0, 0, 0, 32'h0000_0020, 0));
        // just outside, then exactly at the window
        pending_items.push_back(make_item(OP_BUTTON, 4, 3, 1, 1, 4, 0, 0, 0, 1000, 0));
        pending_items.push_back(make_item(OP_BUTTON, 4, 3, 1, 1, 4, 0, 0, 0, 1301, 0));
        pending_items.push_back(make_item(OP_BUTTON, 4, 3, 0, 1, 4, 0, 0, 0, 1601, 0));
        // release of another button does not pair
        pending_items.push_back(make_item(OP_BUTTON, 2, 6, 0, 4, 1, 2, 3, 4, 32'hffff_ffff, 2));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gen_tick = 32'd5000;

        // reset settings, no idling
        add_directed();
        add_random(50);
        drain();

        write_reg(CFG_WINDOW, 16'hffff);
        write_reg(CFG_DISTANCE, 16'd0);
        send_idle_pct = 79;
        add_random(50);
        drain();

        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_DISTANCE, 16'hffff);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        add_random(50);
        drain();

        write_reg(CFG_WINDOW, 16'd1000);
        write_reg(CFG_DISTANCE, 16'd20);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        add_random(50);
        drain();

        $display("%0d items over four register settings and idling mixes, %0d events checked",
                 items_sent, events_seen);
        $display("%0d clicks and %0d double clicks among them", clicks_seen, doubles_seen);
        if (mismatches == 0) begin
            $display("pointer_click_motion_detector test passed");
        end else begin
            $display("pointer_click_motion_detector test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pcmd_pkg.sv
rtl/pcmd_state_ram.sv
rtl/pcmd_update.sv
rtl/pcmd_event_queue.sv
rtl/pointer_click_motion_detector.sv
test/pointer_click_motion_detector_tb.sv
